FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix inverter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mig_pkg.sv
// ---------------------------------------------------------------------------
// mig_pkg
// Types and constants shared by the matrix inverter controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mig_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int SIZE_W    = 4;
    localparam int DIV_STEPS = 48;

    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_IDENT,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_P2_RD,
        ST_P2_CHK,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ROW,
        ST_FAC_RD,
        ST_FAC_CAP,
        ST_MUL_RD,
        ST_MUL_X,
        ST_MUL_WR,
        ST_COL,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_IDENT,
        OP_ADD,
        OP_CAP_PIVOT,
        OP_DIV_START,
        OP_DIV_WRITE,
        OP_CAP_FACTOR,
        OP_MUL,
        OP_MUL_WRITE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] rd_b;
        logic [ADDR_W-1:0] wr;
        logic              diag;
        logic              one;
        logic              last;
        logic              sing;
        logic              clr_ovf;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic div_done;
        logic out_taken;
    } sts_t;

endpackage

FILE: rtl/matrix_inverse_gauss_jordan.sv
// ---------------------------------------------------------------------------
// matrix_inverse_gauss_jordan
// Q16.16 square matrix inverter by Gauss-Jordan elimination.
// ---------------------------------------------------------------------------
// The block loads n*n elements row-major, one beat per cycle, then inverts
// the matrix and streams n*n result beats row-major with tlast on the final
// one. Load, computation and readout run one after another; no input beat is
// taken until the last result beat is accepted. Computation time is set by
// the 48-step restoring dividers used to normalize each pivot row, and
// grows when a zero pivot needs a row added. A singular matrix reports
// zeros with the singular flag; any saturation during elimination raises
// overflowed.
`timescale 1ns / 1ps

module matrix_inverse_gauss_jordan
    import mig_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] inverse_value
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] singular, [1] overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // [3:0] matrix_size
);

    cmd_t                     cmd;
    sts_t                     sts;
    logic signed [DATA_W-1:0] out_data;
    logic                     out_sing, out_ovf;

    assign cfg_ready = 1'b1;

    mig_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    mig_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   ($signed(s_tdata)),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_last  (m_tlast),
        .out_sing  (out_sing),
        .out_ovf   (out_ovf)
    );

    assign m_tdata = out_data;
    assign m_tuser = {out_ovf, out_sing};

endmodule

FILE: rtl/mig_div.sv
// ---------------------------------------------------------------------------
// mig_div
// Restoring Q16.16 divider, one quotient bit per cycle, saturating result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mig_div
    import mig_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [DATA_W-1:0] p,
    output logic                     done,
    output logic signed [DATA_W-1:0] q,
    output logic                     ovf
);

    localparam int DD_W  = DATA_W + 16;
    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DD_W-1:0]   dd_reg, dd_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   rem_sh;
    logic              ge;
    logic [DATA_W-1:0] ux;
    logic [DATA_W-1:0] up;

    always_comb
    begin
        ux        = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
        up        = p[DATA_W-1] ? DATA_W'(-p) : DATA_W'(p);
        rem_sh    = {rem_reg[DATA_W-1:0], dd_reg[DD_W-1]};
        ge        = rem_sh >= {1'b0, d_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dd_next   = dd_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dd_next   = {ux, 16'b0};
            d_next    = up;
            neg_next  = x[DATA_W-1] ^ p[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sh - {1'b0, d_reg} : rem_sh;
            dd_next  = {dd_reg[DD_W-2:0], ge};
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dd_reg  <= dd_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (neg_reg)
            ovf = dd_reg > DD_W'(48'h0000_8000_0000);
        else
            ovf = dd_reg > DD_W'(48'h0000_7FFF_FFFF);
        if (ovf)
            q = neg_reg ? SAT_MIN : SAT_MAX;
        else if (neg_reg)
            q = -$signed(dd_reg[DATA_W-1:0]);
        else
            q = $signed(dd_reg[DATA_W-1:0]);
    end

    assign done = done_reg;

endmodule

FILE: rtl/mig_dpath.sv
// ---------------------------------------------------------------------------
// mig_dpath
// Matrix stores, saturating add, divide and multiply-subtract lanes, output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mig_dpath
    import mig_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic signed [DATA_W-1:0] in_data,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_data,
    output logic                     out_last,
    output logic                     out_sing,
    output logic                     out_ovf
);

    localparam int DEPTH = MAX_DIM << IDX_W;

    logic signed [DATA_W-1:0] w_mem [DEPTH];
    logic signed [DATA_W-1:0] v_mem [DEPTH];

    logic signed [DATA_W-1:0] aw_reg, bw_reg, av_reg, bv_reg;
    logic signed [DATA_W-1:0] p_reg, f_reg;
    logic signed [63:0]       pw_reg, pv_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_last_reg, out_sing_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     ovf_reg, ovf_next;

    logic                     w_we, v_we, ovf_set;
    logic signed [DATA_W-1:0] w_wd, v_wd;
    logic                     div_start, dw_done, dv_done, dw_ovf, dv_ovf;
    logic signed [DATA_W-1:0] dw_q, dv_q;
    logic signed [48:0]       add_w, add_v, sub_w, sub_v;

    function automatic logic signed [DATA_W-1:0] sat49(input logic signed [48:0] v);
        if (v > 49'(SAT_MAX))
            return SAT_MAX;
        else if (v < 49'(SAT_MIN))
            return SAT_MIN;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic ovf49(input logic signed [48:0] v);
        return (v > 49'(SAT_MAX)) || (v < 49'(SAT_MIN));
    endfunction

    function automatic logic signed [48:0] qshift(input logic signed [63:0] v);
        logic signed [63:0] adj;
        adj = v + (v < 0 ? 64'sd65535 : 64'sd0);
        return 49'(adj >>> 16);
    endfunction

    assign div_start = cmd.op == OP_DIV_START;

    mig_div u_div_w (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (aw_reg),
        .p     (p_reg),
        .done  (dw_done),
        .q     (dw_q),
        .ovf   (dw_ovf)
    );

    mig_div u_div_v (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (av_reg),
        .p     (p_reg),
        .done  (dv_done),
        .q     (dv_q),
        .ovf   (dv_ovf)
    );

    always_comb
    begin
        add_w   = 49'(aw_reg) + 49'(bw_reg);
        add_v   = 49'(av_reg) + 49'(bv_reg);
        sub_w   = 49'(aw_reg) - qshift(pw_reg);
        sub_v   = 49'(av_reg) - qshift(pv_reg);
        w_we    = 1'b0;
        v_we    = 1'b0;
        w_wd    = in_data;
        v_wd    = '0;
        ovf_set = 1'b0;
        case (cmd.op)
            OP_LOAD:
            begin
                w_we = 1'b1;
            end
            OP_IDENT:
            begin
                v_we = 1'b1;
                v_wd = cmd.one ? Q_ONE : '0;
            end
            OP_ADD:
            begin
                w_we    = 1'b1;
                v_we    = 1'b1;
                w_wd    = sat49(add_w);
                v_wd    = sat49(add_v);
                ovf_set = ovf49(add_w) | ovf49(add_v);
            end
            OP_DIV_WRITE:
            begin
                w_we    = 1'b1;
                v_we    = 1'b1;
                w_wd    = cmd.diag ? Q_ONE : dw_q;
                v_wd    = dv_q;
                ovf_set = dv_ovf | (dw_ovf & ~cmd.diag);
            end
            OP_MUL_WRITE:
            begin
                w_we    = 1'b1;
                v_we    = 1'b1;
                w_wd    = cmd.diag ? '0 : sat49(sub_w);
                v_wd    = sat49(sub_v);
                ovf_set = ovf49(sub_v) | (ovf49(sub_w) & ~cmd.diag);
            end
            default:
            begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[cmd.wr] <= w_wd;
        if (v_we)
            v_mem[cmd.wr] <= v_wd;
        if (cmd.rd_en)
        begin
            aw_reg <= w_mem[cmd.rd_a];
            bw_reg <= w_mem[cmd.rd_b];
            av_reg <= v_mem[cmd.rd_a];
            bv_reg <= v_mem[cmd.rd_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAP_PIVOT)
            p_reg <= aw_reg;
        if (cmd.op == OP_CAP_FACTOR)
            f_reg <= aw_reg;
        if (cmd.op == OP_MUL)
        begin
            pw_reg <= bw_reg * f_reg;
            pv_reg <= bv_reg * f_reg;
        end
        if (cmd.op == OP_OUT)
        begin
            out_data_reg <= cmd.sing ? '0 : av_reg;
            out_last_reg <= cmd.last;
            out_sing_reg <= cmd.sing;
        end
    end

    always_comb
    begin
        ovf_next       = cmd.clr_ovf ? 1'b0 : (ovf_reg | ovf_set);
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.op == OP_OUT)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.a_zero    = aw_reg == '0;
    assign sts.div_done  = dw_done & dv_done;
    assign sts.out_taken = out_valid_reg & out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_sing  = out_sing_reg;
    assign out_ovf   = ovf_reg;

endmodule

FILE: rtl/mig_ctrl.sv
// ---------------------------------------------------------------------------
// mig_ctrl
// Sequencer for load, elimination passes and result readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mig_ctrl
    import mig_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cfg_valid,
    input  logic [SIZE_W-1:0] cfg_data,
    output cmd_t              cmd,
    input  sts_t              sts
);

    localparam logic [SIZE_W-1:0] DIM_MAX = SIZE_W'(MAX_DIM);
    localparam logic [SIZE_W-1:0] DIM_RST = SIZE_W'(MAX_DIM < 8 ? MAX_DIM : 8);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [IDX_W-1:0]  c_reg, c_next, k_reg, k_next, r_reg, r_next, i_reg, i_next;
    logic              sing_reg, sing_next;

    function automatic logic lst(input logic [IDX_W-1:0] v, input logic [SIZE_W-1:0] n);
        return SIZE_W'(v) == n - 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg     <= DIM_RST;
            row_reg   <= '0;
            col_reg   <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            i_reg     <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            i_reg     <= i_next;
            sing_reg  <= sing_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        sing_next  = sing_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = OP_NOP;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    cmd.wr = {row_reg, col_reg};
                    if (lst(col_reg, n_reg))
                    begin
                        col_next = '0;
                        if (lst(row_reg, n_reg))
                        begin
                            row_next    = '0;
                            cmd.clr_ovf = 1'b1;
                            sing_next   = 1'b0;
                            state_next  = ST_IDENT;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            ST_IDENT:
            begin
                cmd.op  = OP_IDENT;
                cmd.wr  = {row_reg, col_reg};
                cmd.one = row_reg == col_reg;
                if (lst(col_reg, n_reg))
                begin
                    col_next = '0;
                    if (lst(row_reg, n_reg))
                    begin
                        row_next   = '0;
                        c_next     = '0;
                        state_next = ST_PIV_RD;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_PIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {c_reg, c_reg};
                state_next = ST_PIV_CHK;
            end
            ST_PIV_CHK:
            begin
                cmd.op = OP_CAP_PIVOT;
                if (sts.a_zero)
                begin
                    if (lst(c_reg, n_reg))
                    begin
                        sing_next  = 1'b1;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        k_next     = c_reg + 1'b1;
                        state_next = ST_SRCH_RD;
                    end
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_DIV_RD;
                end
            end
            ST_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {k_reg, c_reg};
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK:
            begin
                if (!sts.a_zero)
                begin
                    i_next     = '0;
                    state_next = ST_ADD_RD;
                end
                else if (lst(k_reg, n_reg))
                begin
                    sing_next  = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_ADD_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {c_reg, i_reg};
                cmd.rd_b   = {k_reg, i_reg};
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                cmd.op = OP_ADD;
                cmd.wr = {c_reg, i_reg};
                if (lst(i_reg, n_reg))
                begin
                    state_next = ST_P2_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ADD_RD;
                end
            end
            ST_P2_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {c_reg, c_reg};
                state_next = ST_P2_CHK;
            end
            ST_P2_CHK:
            begin
                cmd.op = OP_CAP_PIVOT;
                if (sts.a_zero)
                begin
                    sing_next  = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_DIV_RD;
                end
            end
            ST_DIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {c_reg, k_reg};
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.op     = OP_DIV_START;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.op   = OP_DIV_WRITE;
                    cmd.wr   = {c_reg, k_reg};
                    cmd.diag = k_reg == c_reg;
                    if (lst(k_reg, n_reg))
                    begin
                        r_next     = '0;
                        state_next = ST_ROW;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_DIV_RD;
                    end
                end
            end
            ST_ROW:
            begin
                if (r_reg == c_reg)
                begin
                    if (lst(r_reg, n_reg))
                        state_next = ST_COL;
                    else
                        r_next = r_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FAC_RD;
                end
            end
            ST_FAC_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {r_reg, c_reg};
                state_next = ST_FAC_CAP;
            end
            ST_FAC_CAP:
            begin
                cmd.op     = OP_CAP_FACTOR;
                k_next     = '0;
                state_next = ST_MUL_RD;
            end
            ST_MUL_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {r_reg, k_reg};
                cmd.rd_b   = {c_reg, k_reg};
                state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                cmd.op     = OP_MUL;
                state_next = ST_MUL_WR;
            end
            ST_MUL_WR:
            begin
                cmd.op   = OP_MUL_WRITE;
                cmd.wr   = {r_reg, k_reg};
                cmd.diag = k_reg == c_reg;
                if (lst(k_reg, n_reg))
                begin
                    if (lst(r_reg, n_reg))
                    begin
                        state_next = ST_COL;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MUL_RD;
                end
            end
            ST_COL:
            begin
                if (lst(c_reg, n_reg))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_PIV_RD;
                end
            end
            ST_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_a   = {row_reg, col_reg};
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                cmd.op     = OP_OUT;
                cmd.last   = lst(row_reg, n_reg) && lst(col_reg, n_reg);
                cmd.sing   = sing_reg;
                state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (sts.out_taken)
                begin
                    state_next = ST_OUT_RD;
                    if (lst(col_reg, n_reg))
                    begin
                        col_next = '0;
                        if (lst(row_reg, n_reg))
                        begin
                            row_next   = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_valid)
        begin
            if (cfg_data == '0)
                n_next = SIZE_W'(1);
            else if (cfg_data > DIM_MAX)
                n_next = DIM_MAX;
            else
                n_next = cfg_data;
            row_next = '0;
            col_next = '0;
        end
    end

endmodule

FILE: rtl/mig_checker.sv
// ---------------------------------------------------------------------------
// mig_checker
// Port-level checks for the matrix inverter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mig_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
    `CHK_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled beat changed")
    `CHK_IMPLY(a_no_overlap, clk, rst_n, m_tvalid, !s_tready, "input taken during readout")
    `CHK_IMPLY(a_sing_zero, clk, rst_n, m_tvalid && m_tuser[0], m_tdata == 32'h0, "singular beat nonzero")

endmodule

bind matrix_inverse_gauss_jordan mig_checker u_mig_checker (.*);

FILE: bench/tb_matrix_inverse_gauss_jordan.sv
// ---------------------------------------------------------------------------
// tb_matrix_inverse_gauss_jordan
// Self-checking bench for the Q16.16 Gauss-Jordan matrix inverter.
// ---------------------------------------------------------------------------
// Matrices of several sizes are streamed in, one element per beat, while the
// result stream is stalled on its own pattern. A behavioral inverter in the
// bench computes each expected inverse with its flags; every result beat is
// compared against the oldest expected one. A short directed table covers
// the identity, zero pivot repair, singular and saturating matrices, and
// size writes of 0 and above the maximum, then random matrices follow.
`timescale 1ns / 1ps

module tb_matrix_inverse_gauss_jordan;
    import mig_pkg::*;

    localparam int Q1 = 65536;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        sing;
        logic        ovf;
    } inv_beat_t;

    typedef struct {
        logic [3:0]  size_wr;
        logic        do_cfg;
        logic [31:0] elem;
        logic        has_exp;
        inv_beat_t   exp_beat;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    logic signed [31:0] work_q [64];
    logic signed [31:0] inv_q [64];
    int        size_n;
    int        loaded;
    bit        sat_seen;
    inv_beat_t inverse_fifo [$];
    inv_beat_t pinned_fifo [$];
    bit        pinned_valid [$];
    int        errors = 0;
    longint    cycles = 0;
    int        stall_phase = 0;

    matrix_inverse_gauss_jordan #(.MAX_DIM(8)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [31:0] clip(input longint v);
        if (v > 64'sd2147483647)
        begin
            sat_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            sat_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic bit gauss_jordan(input int n);
        int p;
        longint f;
        longint prod;
        bit found;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                inv_q[r*n+c] = (r == c) ? Q1 : 0;
        for (int c = 0; c < n; c++)
        begin
            if (work_q[c*n+c] == 0)
            begin
                found = 1'b0;
                for (int k = c + 1; k < n; k++)
                    if (!found && work_q[k*n+c] != 0)
                    begin
                        found = 1'b1;
                        for (int i = 0; i < n; i++)
                        begin
                            work_q[c*n+i] = clip(longint'(work_q[c*n+i]) + work_q[k*n+i]);
                            inv_q[c*n+i] = clip(longint'(inv_q[c*n+i]) + inv_q[k*n+i]);
                        end
                    end
            end
            p = work_q[c*n+c];
            if (p == 0)
                return 1'b1;
            for (int k = 0; k < n; k++)
            begin
                inv_q[c*n+k] = clip((longint'(inv_q[c*n+k]) * Q1) / p);
                if (k != c)
                    work_q[c*n+k] = clip((longint'(work_q[c*n+k]) * Q1) / p);
            end
            work_q[c*n+c] = Q1;
            for (int r = 0; r < n; r++)
            begin
                if (r != c)
                begin
                    f = work_q[r*n+c];
                    for (int k = 0; k < n; k++)
                    begin
                        prod = (longint'(inv_q[c*n+k]) * f) / Q1;
                        inv_q[r*n+k] = clip(longint'(inv_q[r*n+k]) - prod);
                        if (k != c)
                        begin
                            prod = (longint'(work_q[c*n+k]) * f) / Q1;
                            work_q[r*n+k] = clip(longint'(work_q[r*n+k]) - prod);
                        end
                    end
                    work_q[r*n+c] = 0;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic take_element(input logic [31:0] elem);
        bit sing;
        inv_beat_t b;
        if (loaded >= size_n * size_n)
            loaded = 0;
        work_q[loaded] = elem;
        loaded++;
        if (loaded < size_n * size_n)
            return;
        loaded = 0;
        sat_seen = 1'b0;
        sing = gauss_jordan(size_n);
        for (int i = 0; i < size_n * size_n; i++)
        begin
            b.value = sing ? 32'd0 : inv_q[i];
            b.last = (i + 1 == size_n * size_n);
            b.sing = sing;
            b.ovf = sat_seen;
            inverse_fifo.push_back(b);
        end
    endtask

    task automatic write_size(input logic [3:0] v);
        while (inverse_fifo.size() != 0)
            @(posedge clk);
        repeat (6000) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_n = (v == 0) ? 1 : (v > 8) ? 8 : v;
        loaded = 0;
    endtask

    task automatic send_element(input logic [31:0] elem, input bit has_exp,
                                input inv_beat_t exp_beat);
        s_tvalid <= 1'b1;
        s_tdata <= elem;
        do @(posedge clk); while (!s_tready);
        take_element(elem);
        if (has_exp)
        begin
            pinned_fifo.push_back(exp_beat);
            pinned_valid.push_back(1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        inv_beat_t e;
        inv_beat_t pin;
        if (m_tvalid && m_tready)
        begin
            if (inverse_fifo.size() == 0)
            begin
                $error("result beat with no expectation: value %h", m_tdata);
                errors = errors + 1;
            end
            else
            begin
                e = inverse_fifo.pop_front();
                if (e.last && pinned_fifo.size() != 0)
                begin
                    pin = pinned_fifo.pop_front();
                    void'(pinned_valid.pop_front());
                    if (pin !== e)
                    begin
                        $error("table row: expected %h, predicted %h", pin, e);
                        errors = errors + 1;
                    end
                end
                if (m_tdata !== e.value)
                begin
                    $error("inverse_value: expected %h, actual %h", e.value, m_tdata);
                    errors = errors + 1;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_element: expected %b, actual %b", e.last, m_tlast);
                    errors = errors + 1;
                end
                if (m_tuser[0] !== e.sing)
                begin
                    $error("singular: expected %b, actual %b", e.sing, m_tuser[0]);
                    errors = errors + 1;
                end
                if (m_tuser[1] !== e.ovf)
                begin
                    $error("overflowed: expected %b, actual %b", e.ovf, m_tuser[1]);
                    errors = errors + 1;
                end
            end
        end
        stall_phase <= stall_phase + 1;
        if (stall_phase % 400 < 150)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 2) != 0);
    end

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'd0;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 8 * Q1)) - 4 * Q1);
        endcase
    endfunction

    row_t stim [$];

    task automatic add_row(input bit do_cfg, input logic [3:0] sz, input logic [31:0] el,
                           input bit he, input inv_beat_t eb);
        row_t r;
        r.do_cfg = do_cfg;
        r.size_wr = sz;
        r.elem = el;
        r.has_exp = he;
        r.exp_beat = eb;
        stim.push_back(r);
    endtask

    initial
    begin
        inv_beat_t none;
        int n;
        none = '0;
        size_n = 8;
        loaded = 0;
        // size 0 is taken as 1: inverse of 2.0 is 0.5
        add_row(1, 4'd0, 32'h0002_0000, 1, '{32'h0000_8000, 1'b1, 1'b0, 1'b0});
        add_row(1, 4'd1, 32'h0000_0000, 1, '{32'h0, 1'b1, 1'b1, 1'b0});
        add_row(0, 0, 32'h0000_0001, 1, '{32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1});
        add_row(0, 0, 32'h8000_0000, 1, '{32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0});
        add_row(0, 0, 32'hFFFF_FFFF, 1, '{32'h8000_0000, 1'b1, 1'b0, 1'b1});
        // 2x2 with zero pivot: repaired by adding the lower row
        add_row(1, 4'd2, 32'h0, 0, none);
        add_row(0, 0, 32'h0001_0000, 0, none);
        add_row(0, 0, 32'h0001_0000, 0, none);
        add_row(0, 0, 32'h0, 0, none);
        // 2x2 singular, all zeros
        for (int i = 0; i < 4; i++)
            add_row(0, 0, 32'h0, i == 3, '{32'h0, 1'b1, 1'b1, 1'b0});
        // 2x2 with extreme entries
        add_row(0, 0, 32'h7FFF_FFFF, 0, none);
        add_row(0, 0, 32'h8000_0000, 0, none);
        add_row(0, 0, 32'h8000_0000, 0, none);
        add_row(0, 0, 32'h7FFF_FFFF, 0, none);
        // size above max taken as 8; partial load discarded by next write
        add_row(1, 4'd15, 32'h1234_5678, 0, none);
        add_row(1, 4'd3, 32'h0001_0000, 0, none);
        for (int i = 1; i < 9; i++)
            add_row(0, 0, (i % 4 == 0) ? 32'h0001_0000 : 32'h0, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim[i])
        begin
            if (stim[i].do_cfg)
            begin
                s_tvalid <= 1'b0;
                write_size(stim[i].size_wr);
            end
            send_element(stim[i].elem, stim[i].has_exp, stim[i].exp_beat);
            gap();
        end

        for (int m = 0; m < 22; m++)
        begin
            s_tvalid <= 1'b0;
            n = (m % 11 == 10) ? 8 : $urandom_range(1, 4);
            if (m == 21)
                n = 8;
            write_size(4'(n));
            for (int i = 0; i < n * n; i++)
            begin
                send_element(rand_elem(), 0, none);
                gap();
            end
        end
        s_tvalid <= 1'b0;

        while (inverse_fifo.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
